FILE: rtl/cer_pkg.sv
// Shared types and constants of the cluster energy recalibration block.
package cer_pkg;

   localparam int IDX_W    = 15;
   localparam int COEF_W   = 16;
   localparam int E_W      = 24;
   localparam int DIFF_W   = 25;
   localparam int RAW_W    = 26;
   localparam int WGT_W    = 42;
   localparam int PROD_W   = 42;
   localparam int NUM_W    = 65;
   localparam int MPROD_W  = 45;
   localparam int WLO_W    = 21;
   localparam int DIV_STEPS = 24;
   localparam int CNT_W    = 5;
   localparam int REQ_DATA_W = 80;

   localparam logic signed [RAW_W-1:0] RAW_MAX = 26'sd33554431;
   localparam logic signed [RAW_W-1:0] RAW_MIN = -RAW_MAX;
   localparam logic signed [WGT_W-1:0] WGT_MAX = 42'sd2199023255551;
   localparam logic signed [WGT_W-1:0] WGT_MIN = -WGT_MAX;
   localparam logic [E_W-1:0] E_MAX = '1;

   // Values carried by the input tuser field.
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_TOWER = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_NUM_LO,
      S_NUM_HI,
      S_NUM_ADD,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic acc;
      logic num_lo;
      logic num_hi;
      logic num_add;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic skip_div;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/cer_ctrl.sv
// Controller state machine sequencing tower accumulation and the final division.
module cer_ctrl import cer_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_action,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == ACT_TOWER)) begin
               state_in = S_MUL;
            end
         end
         S_MUL:     state_in = S_ACC;
         S_ACC:     state_in = status.last ? S_NUM_LO : S_IDLE;
         S_NUM_LO:  state_in = status.skip_div ? S_DONE : S_NUM_HI;
         S_NUM_HI:  state_in = S_NUM_ADD;
         S_NUM_ADD: state_in = S_CHECK;
         S_CHECK:   state_in = S_DIV;
         S_DIV:     state_in = status.div_last ? S_DONE : S_DIV;
         S_DONE: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.capture = accept;
      case (state_ff)
         S_MUL:     cmd.mul      = 1'b1;
         S_ACC:     cmd.acc      = 1'b1;
         S_NUM_LO:  cmd.num_lo   = 1'b1;
         S_NUM_HI:  cmd.num_hi   = 1'b1;
         S_NUM_ADD: cmd.num_add  = 1'b1;
         S_CHECK:   cmd.div_init = 1'b1;
         S_DIV:     cmd.div_step = 1'b1;
         S_DONE:    cmd.out_load = status.out_free;
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/cer_dpath.sv
// Datapath: gain memory, tower accumulators, numerator multiplier and divider.
module cer_dpath import cer_pkg::*; #(
   parameter int TOWERS         = 32768,
   parameter int GAIN_FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_action,
   input  logic [IDX_W-1:0]  req_tower_index,
   input  logic [COEF_W-1:0] req_coefficient,
   input  logic [E_W-1:0]    req_partial_sum,
   input  logic [E_W-1:0]    req_cluster_energy,
   input  logic              req_last_tower,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [E_W-1:0]    rsp_recal_energy,
   output logic              rsp_sum_fault,
   output logic              rsp_saturated
);

   localparam int AW    = (TOWERS > 1) ? $clog2(TOWERS) : 1;
   localparam int DW    = DIFF_W + GAIN_FRAC_BITS;
   localparam int NHI_W = NUM_W - DIV_STEPS;
   localparam int CW    = (DW > NHI_W) ? DW : NHI_W;

   logic [COEF_W-1:0] gain_mem [TOWERS];

   logic [AW-1:0]     addr;
   logic              in_range;

   logic [COEF_W-1:0] gain_ff;
   logic              in_range_ff;
   logic              last_ff;
   logic [E_W-1:0]    ps_ff;
   logic [E_W-1:0]    ecore_ff;

   logic [E_W-1:0]    prev_ff;
   logic              first_ff;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [COEF_W:0]   gain_s;
   logic signed [RAW_W-1:0]  raw_ff, raw_in;
   logic signed [WGT_W-1:0]  wgt_ff, wgt_in;
   logic signed [RAW_W:0]    raw_sum;
   logic signed [WGT_W:0]    wgt_sum;
   logic              raw_pos;
   logic              wgt_pos;

   logic [MPROD_W-1:0] mprod_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DW-1:0]      den;
   logic [DW-1:0]      rem_ff;
   logic [DW:0]        trial;
   logic               qbit;
   logic [DIV_STEPS-1:0] shift_ff;
   logic               sat_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic               rsp_valid_ff;
   logic [E_W-1:0]     rsp_energy_ff;
   logic               rsp_fault_ff;
   logic               rsp_sat_ff;

   assign addr     = AW'(req_tower_index);
   assign in_range = (17'(req_tower_index) < 17'(TOWERS));

   // Item capture; loads write the table, tower items read their gain.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if ((req_action == ACT_LOAD) && in_range) begin
            gain_mem[addr] <= req_coefficient;
         end
         gain_ff     <= gain_mem[addr];
         in_range_ff <= in_range;
         last_ff     <= req_last_tower;
         ps_ff       <= req_partial_sum;
         ecore_ff    <= req_cluster_energy;
      end
   end

   assign diff_in = first_ff ? signed'({1'b0, ps_ff})
                             : signed'({1'b0, ps_ff}) - signed'({1'b0, prev_ff});
   assign gain_s  = in_range_ff ? signed'({1'b0, gain_ff}) : '0;
   assign prod_in = diff_in * gain_s;

   assign raw_sum = (RAW_W + 1)'(raw_ff) + (RAW_W + 1)'(diff_ff);
   assign wgt_sum = (WGT_W + 1)'(wgt_ff) + (WGT_W + 1)'(prod_ff);

   always_comb begin
      if (raw_sum > (RAW_W + 1)'(RAW_MAX)) begin
         raw_in = RAW_MAX;
      end else if (raw_sum < (RAW_W + 1)'(RAW_MIN)) begin
         raw_in = RAW_MIN;
      end else begin
         raw_in = RAW_W'(raw_sum);
      end
      if (wgt_sum > (WGT_W + 1)'(WGT_MAX)) begin
         wgt_in = WGT_MAX;
      end else if (wgt_sum < (WGT_W + 1)'(WGT_MIN)) begin
         wgt_in = WGT_MIN;
      end else begin
         wgt_in = WGT_W'(wgt_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         first_ff <= 1'b1;
         raw_ff   <= '0;
         wgt_ff   <= '0;
      end else if (cmd.out_load) begin
         prev_ff  <= '0;
         first_ff <= 1'b1;
         raw_ff   <= '0;
         wgt_ff   <= '0;
      end else begin
         if (cmd.mul) begin
            prev_ff  <= ps_ff;
            first_ff <= 1'b0;
         end
         if (cmd.acc) begin
            raw_ff <= raw_in;
            wgt_ff <= wgt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
      end
   end

   assign raw_pos = (raw_ff > 0);
   assign wgt_pos = (wgt_ff > 0);

   // The numerator ecore * weighted is built from two partial products.
   always_ff @(posedge clock) begin
      if (cmd.num_lo) begin
         mprod_ff <= MPROD_W'(ecore_ff) * MPROD_W'(wgt_ff[WLO_W-1:0]);
      end else if (cmd.num_hi) begin
         num_ff   <= NUM_W'(mprod_ff);
         mprod_ff <= MPROD_W'(ecore_ff) * MPROD_W'(wgt_ff[WGT_W-2:WLO_W]);
      end else if (cmd.num_add) begin
         num_ff <= num_ff + (NUM_W'(mprod_ff) << WLO_W);
      end
   end

   assign den   = {raw_ff[DIFF_W-1:0], {GAIN_FRAC_BITS{1'b0}}};
   assign trial = {rem_ff, shift_ff[DIV_STEPS-1]};
   assign qbit  = (trial >= {1'b0, den});

   // Restoring division, one quotient bit per cycle. The quotient overflows
   // exactly when the upper numerator bits already reach the divisor.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         sat_ff   <= (CW'(num_ff[NUM_W-1:DIV_STEPS]) >= CW'(den));
         rem_ff   <= DW'(num_ff[NUM_W-1:DIV_STEPS]);
         shift_ff <= num_ff[DIV_STEPS-1:0];
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff   <= qbit ? DW'(trial - {1'b0, den}) : DW'(trial);
         shift_ff <= {shift_ff[DIV_STEPS-2:0], qbit};
         cnt_ff   <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (!raw_pos) begin
            rsp_energy_ff <= ecore_ff;
            rsp_fault_ff  <= 1'b1;
            rsp_sat_ff    <= 1'b0;
         end else if (!wgt_pos) begin
            rsp_energy_ff <= '0;
            rsp_fault_ff  <= 1'b0;
            rsp_sat_ff    <= 1'b0;
         end else if (sat_ff) begin
            rsp_energy_ff <= E_MAX;
            rsp_fault_ff  <= 1'b0;
            rsp_sat_ff    <= 1'b1;
         end else begin
            rsp_energy_ff <= shift_ff;
            rsp_fault_ff  <= 1'b0;
            rsp_sat_ff    <= 1'b0;
         end
      end
   end

   assign status.last     = last_ff;
   assign status.skip_div = !(raw_pos && wgt_pos);
   assign status.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_recal_energy = rsp_energy_ff;
   assign rsp_sum_fault    = rsp_fault_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

FILE: rtl/cluster_energy_recalibration.sv
// Top level of the cluster energy recalibration block.
// The request channel carries two kinds of transaction, told apart by
// req_tuser: a load writes one gain coefficient into the per-tower table,
// a tower transaction adds one tower to the current cluster, and req_tlast
// marks the cluster's final tower. The response channel delivers one
// transaction per cluster: the recalibrated energy and two flags.
// A load is taken without leaving the idle state. A tower that is not the
// last goes through capture with table read, multiply by the gain and
// accumulate. The last tower adds a two-step partial-product multiply, a
// numerator add, an overflow check and a 24-step restoring divider, one
// quotient bit per cycle; when the raw or the weighted sum is not positive,
// the response is loaded after the first partial product, with no division.
// Reset clears the accumulators and the state machine; the gain table is
// not cleared and must be loaded before use. The result waits in an output
// register; while it is not taken the next cluster's result cannot be
// written; a finished cluster holds off requests until the slot is free.
module cluster_energy_recalibration import cer_pkg::*; #(
   parameter int TOWERS         = 32768,
   parameter int GAIN_FRAC_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tower_index[14:0], coefficient[30:15], partial_sum[54:31],
   // cluster_energy[78:55], zero fill[79]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // recal_energy[23:0]
   output logic [E_W-1:0]        rsp_tdata,
   // sum_fault[0], saturated[1]
   output logic [1:0]            rsp_tuser
);

   cmd_type    cmd;
   status_type status;
   logic       fault;
   logic       sat;

   cer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cer_dpath #(
      .TOWERS         (TOWERS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_tuser),
      .req_tower_index    (req_tdata[14:0]),
      .req_coefficient    (req_tdata[30:15]),
      .req_partial_sum    (req_tdata[54:31]),
      .req_cluster_energy (req_tdata[78:55]),
      .req_last_tower     (req_tlast),
      .rsp_ready          (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_recal_energy   (rsp_tdata),
      .rsp_sum_fault      (fault),
      .rsp_saturated      (sat)
   );

   assign rsp_tuser = {sat, fault};

`ifndef SYNTHESIS
   // A load transaction never leaves the controller busy.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACT_LOAD) |=> req_tready)
      else $error("request side stalled after a load");

   // A tower transaction always occupies the datapath for the next cycle.
   a_tower_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACT_TOWER) |=> !req_tready)
      else $error("tower accepted while the datapath was still busy");

   // The two flags exclude each other.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("fault and saturation flagged together");

   // A clipped result is the full-scale value.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata == E_MAX))
      else $error("saturated result is not full scale");
`endif

endmodule

FILE: bench/tb_cluster_energy_recalibration.sv
`timescale 1ns / 1ps
// Self-checking testbench of the cluster energy recalibration block.
module tb_cluster_energy_recalibration;
   import cer_pkg::*;

   localparam int     TOWERS         = 32768;
   localparam int     GAIN_FRAC_BITS = 14;
   localparam longint RAW_LIM        = 64'sd33554431;
   localparam longint WGT_LIM        = 64'sd2199023255551;
   localparam int     CYCLE_LIMIT    = 800000;
   localparam int     DRAIN_CYCLES   = 64;

   typedef struct packed {
      logic [E_W-1:0] energy;
      logic           fault;
      logic           sat;
   } recal_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tower_index, coefficient, partial_sum, cluster_energy, zero fill
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // action
   logic                  req_tuser  = ACT_LOAD;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // recal_energy
   logic [E_W-1:0]        rsp_tdata;
   // sum_fault, saturated
   logic [1:0]            rsp_tuser;

   // Own copy of the gain table and the cluster accumulators.
   bit [COEF_W-1:0] gain_copy [TOWERS];
   bit              gain_loaded [TOWERS];
   int unsigned     loaded_list [$];
   logic [E_W-1:0]  prev_partial;
   longint          raw_acc;
   longint          wgt_acc;
   bit              first_pending;
   recal_type       pending_recal [$];

   int unsigned gap_pct        = 0;
   int unsigned stall_pct      = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   cluster_energy_recalibration #(
      .TOWERS         (TOWERS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cluster_energy_recalibration verification failed");
         $finish;
      end
   end

   function automatic longint clamp_acc(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Updates the predicted state with one accepted transaction and queues the
   // recalibrated energy that a last tower produces.
   task automatic predict_request(logic action, logic [IDX_W-1:0] idx,
                                  logic [COEF_W-1:0] coef, logic [E_W-1:0] partial,
                                  logic [E_W-1:0] ecore, logic is_last);
      longint       diff;
      longint       gain;
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      recal_type    res;
      if (action == ACT_LOAD) begin
         gain_copy[idx] = coef;
         if (!gain_loaded[idx]) begin
            gain_loaded[idx] = 1'b1;
            loaded_list.push_back(32'(idx));
         end
      end else begin
         gain = longint'(gain_copy[idx]);
         diff = first_pending ? longint'(partial)
                              : longint'(partial) - longint'(prev_partial);
         prev_partial  = partial;
         first_pending = 1'b0;
         raw_acc = clamp_acc(raw_acc + diff, RAW_LIM);
         wgt_acc = clamp_acc(wgt_acc + diff * gain, WGT_LIM);
         if (is_last) begin
            res = '0;
            if (raw_acc <= 0) begin
               res.energy = ecore;
               res.fault  = 1'b1;
            end else if (wgt_acc > 0) begin
               num = {104'd0, ecore} * {64'd0, wgt_acc};
               den = {64'd0, raw_acc} << GAIN_FRAC_BITS;
               quo = num / den;
               if (quo > {104'd0, E_MAX}) begin
                  res.energy = E_MAX;
                  res.sat    = 1'b1;
               end else begin
                  res.energy = quo[E_W-1:0];
               end
            end
            pending_recal.push_back(res);
            prev_partial  = '0;
            raw_acc       = 0;
            wgt_acc       = 0;
            first_pending = 1'b1;
         end
      end
   endtask

   // Presents one transaction, holding it until the block takes it.
   task automatic send_request(logic action, logic [IDX_W-1:0] idx,
                               logic [COEF_W-1:0] coef, logic [E_W-1:0] partial,
                               logic [E_W-1:0] ecore, logic is_last);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tlast  <= is_last;
      req_tdata  <= {1'b0, ecore, partial, coef, idx};
      do @(posedge clock); while (!req_tready);
      predict_request(action, idx, coef, partial, ecore, is_last);
   endtask

   // A cluster over loaded towers. A well-formed one has a rising cumulative
   // sum; a noisy one jumps about and often ends on zero.
   task automatic send_cluster(int unsigned towers, bit noisy);
      int unsigned      partial;
      int unsigned      scale;
      int unsigned      escale;
      logic [IDX_W-1:0] idx;
      logic [E_W-1:0]   ecore;
      scale   = $urandom_range(1, 23);
      partial = 0;
      for (int unsigned t = 0; t < towers; t++) begin
         if (noisy) begin
            partial = ($urandom_range(3) == 0) ? 0 : ($urandom & 32'hFFFFFF);
         end else begin
            partial = partial + ($urandom & ((1 << scale) - 1));
            if (partial > 32'hFFFFFF) partial = 32'hFFFFFF;
         end
         idx    = IDX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
         escale = $urandom_range(1, 24);
         ecore  = E_W'($urandom & ((1 << escale) - 1));
         send_request(ACT_TOWER, idx, COEF_W'($urandom), E_W'(partial), ecore,
                      t == towers - 1);
      end
   endtask

   always @(posedge clock) begin
      recal_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_recal.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response: energy %h fault %b sat %b",
                        rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
            mismatch_count++;
         end else begin
            want = pending_recal.pop_front();
            if (rsp_tdata !== want.energy || rsp_tuser[0] !== want.fault ||
                rsp_tuser[1] !== want.sat) begin
               if (mismatch_count < 10)
                  $display("response mismatch: energy %h/%h fault %b/%b sat %b/%b (exp/act)",
                           want.energy, rsp_tdata, want.fault, rsp_tuser[0],
                           want.sat, rsp_tuser[1]);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Unity gain, zero raw sum, negative and zero weighted sums, saturation.
   task automatic test_corner_cases();
      gap_pct   = 0;
      stall_pct = 0;
      send_request(ACT_LOAD, 15'd0, 16'h0000, 24'h000000, 24'hFFFFFF, 1'b1);
      send_request(ACT_LOAD, 15'h7FFF, 16'hFFFF, 24'hFFFFFF, 24'h000000, 1'b0);
      send_request(ACT_LOAD, 15'd1, 16'h4000, 24'h555555, 24'hAAAAAA, 1'b0);
      send_request(ACT_LOAD, 15'h5555, 16'hAAAA, 24'hAAAAAA, 24'h555555, 1'b1);
      send_request(ACT_LOAD, 15'h2AAA, 16'h5555, 24'h123456, 24'h654321, 1'b0);
      send_request(ACT_TOWER, 15'd1, 16'hFFFF, 24'd1000, 24'd5000, 1'b1);
      send_request(ACT_TOWER, 15'h7FFF, 16'h0000, 24'h000000, 24'hFFFFFF, 1'b1);
      send_request(ACT_TOWER, 15'd0, 16'h0000, 24'd1000, 24'h000000, 1'b0);
      send_request(ACT_TOWER, 15'h7FFF, 16'h0000, 24'd10, 24'h123456, 1'b1);
      send_request(ACT_TOWER, 15'h7FFF, 16'h0000, 24'd1, 24'hFFFFFF, 1'b1);
      send_request(ACT_TOWER, 15'd0, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
   endtask

   // Drives the weighted accumulator past both of its limits.
   task automatic test_accumulator_clamp();
      for (int i = 0; i < 3; i++) begin
         send_request(ACT_TOWER, 15'h7FFF, 16'h0000, 24'hFFFFFF, 24'h001000, i == 2);
         if (i < 2) send_request(ACT_TOWER, 15'd0, 16'h0000, 24'h000000, 24'h001000, 1'b0);
      end
      // Three falls at full gain clip the sum; three rises then leave it positive.
      for (int i = 0; i < 3; i++) begin
         send_request(ACT_TOWER, 15'd0, 16'h0000, 24'hFFFFFF, 24'h001000, 1'b0);
         send_request(ACT_TOWER, 15'h7FFF, 16'h0000, 24'h000000, 24'h001000, 1'b0);
      end
      for (int i = 0; i < 3; i++) begin
         send_request(ACT_TOWER, 15'h7FFF, 16'h0000, 24'hFFFFFF, 24'h001000, i == 2);
         if (i < 2) send_request(ACT_TOWER, 15'd0, 16'h0000, 24'h000000, 24'h001000, 1'b0);
      end
   endtask

   // The sender holds off until the block has delivered everything owed.
   task automatic test_sender_holds_for_results();
      gap_pct   = 0;
      stall_pct = 56;
      send_cluster(3, 1'b0);
      req_tvalid <= 1'b0;
      while (pending_recal.size() != 0) @(posedge clock);
      send_cluster(2, 1'b0);
   endtask

   task automatic test_random_traffic(int unsigned n_items, int unsigned gap,
                                      int unsigned stall);
      int unsigned       sent;
      int unsigned       towers;
      int unsigned       pick;
      logic [IDX_W-1:0]  idx;
      logic [COEF_W-1:0] coef;
      gap_pct   = gap;
      stall_pct = stall;
      sent      = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            if ($urandom_range(2) == 0)
               idx = IDX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
            else
               idx = IDX_W'($urandom);
            // Gains mostly near unity so that results do not all saturate.
            if ($urandom_range(4) < 3) coef = COEF_W'($urandom_range(8192, 32767));
            else coef = COEF_W'($urandom);
            send_request(ACT_LOAD, idx, coef, E_W'($urandom), E_W'($urandom),
                         1'($urandom));
            sent++;
         end else begin
            towers = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            send_cluster(towers, pick >= 92);
            sent += towers;
         end
      end
   endtask

   initial begin
      prev_partial  = '0;
      raw_acc       = 0;
      wgt_acc       = 0;
      first_pending = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_accumulator_clamp();
      test_random_traffic(460, 0, 0);
      test_sender_holds_for_results();
      test_random_traffic(460, 56, 0);
      test_random_traffic(460, 0, 56);
      test_random_traffic(460, 34, 34);
      req_tvalid <= 1'b0;
      while (pending_recal.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_recal.size() == 0)
         $display("cluster_energy_recalibration verification clean");
      else
         $display("cluster_energy_recalibration verification failed");
      $finish;
   end

endmodule

FILE: cluster_energy_recalibration.f
rtl/cer_pkg.sv
rtl/cer_ctrl.sv
rtl/cer_dpath.sv
rtl/cluster_energy_recalibration.sv
bench/tb_cluster_energy_recalibration.sv
